@@ design/fcull_pkg.sv @@
// ----------------------------------------------------------------------------
// Frustum cull package
// Widths, register indexes and helpers shared by the box culling core.
// ----------------------------------------------------------------------------
package fcull_pkg;

    localparam int COORD_W     = 28;
    localparam int COEF_W      = 16;
    localparam int NORM_W      = 12;
    localparam int PLANE_W     = 64;
    localparam int PLANE_COUNT = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 400;
    localparam int M_TDATA_W   = 8;
    localparam int FRAC_SHIFT  = 12;
    localparam int DIST_SHIFT  = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_BOTTOM = 3'd2,
        REG_TOP    = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5
    } plane_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    function automatic coord_t sat_coord(input logic signed [34:0] v);
        coord_t res;
        if (v > 35'sd134217727) begin
            res = 28'sh7FFFFFF;
        end else if (v < -35'sd134217728) begin
            res = 28'sh8000000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/frustum_aabb_cull_core.sv @@
// ----------------------------------------------------------------------------
// Frustum AABB cull core
// Transforms a local box by an affine model matrix and tests the world box
// against six frustum planes with the p-vertex test.
// ----------------------------------------------------------------------------
// Channel  | Direction | Ports                    | Content
// s_       | in        | tvalid, tready, tdata    | box, model matrix, translation
// m_       | out       | tvalid, tready, tdata    | visible flag
// cfg_     | in        | we, index, wdata         | six packed planes
//
// Each item passes through the stages below on its way to the output register,
// and a new item can enter in every cycle in which that register is empty or taken.
// The per-axis extent products, the extent sums, the saturation, the plane
// products and the plane sums each own one pipeline stage.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears the valid bits and sets all planes to zero.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // row0_linear, row1_linear, row2_linear, shift_x, shift_y, shift_z
    input  logic [fcull_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // visible
    output logic [fcull_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                  cfg_we,
    input  logic [fcull_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcull_pkg::PLANE_W-1:0]         cfg_wdata
);
    import fcull_pkg::*;

    logic              ce;
    logic [4:0]        vld_reg;
    logic [PLANE_W-1:0] plane_reg [PLANE_COUNT];

    coord_t                    lo [3];
    coord_t                    hi [3];
    coord_t                    sh [3];
    logic signed [COEF_W-1:0]  mat [3][3];

    logic signed [43:0]        plo_reg [3][3];
    logic signed [43:0]        phi_reg [3][3];
    coord_t                    sh1_reg [3];
    logic signed [45:0]        amin_reg [3];
    logic signed [45:0]        amax_reg [3];
    coord_t                    sh2_reg [3];
    coord_t                    wmin_reg [3];
    coord_t                    wmax_reg [3];
    logic signed [39:0]        np_reg [PLANE_COUNT][3];
    logic                      vis_reg;

    assign ce       = !vld_reg[4] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[4];
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, vis_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    plane_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[3:0], s_tvalid};
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lo[c] = s_tdata[c*COORD_W +: COORD_W];
            hi[c] = s_tdata[(3+c)*COORD_W +: COORD_W];
            sh[c] = s_tdata[312 + c*COORD_W +: COORD_W];
            for (int r = 0; r < 3; r++) begin
                mat[r][c] = s_tdata[168 + r*48 + c*COEF_W +: COEF_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                sh1_reg[r] <= sh[r];
                for (int c = 0; c < 3; c++) begin
                    plo_reg[r][c] <= mat[r][c] * lo[c];
                    phi_reg[r][c] <= mat[r][c] * hi[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [45:0] smin;
        logic signed [45:0] smax;
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                smin = '0;
                smax = '0;
                for (int c = 0; c < 3; c++) begin
                    if (plo_reg[r][c] < phi_reg[r][c]) begin
                        smin = smin + 46'(plo_reg[r][c]);
                        smax = smax + 46'(phi_reg[r][c]);
                    end else begin
                        smin = smin + 46'(phi_reg[r][c]);
                        smax = smax + 46'(plo_reg[r][c]);
                    end
                end
                amin_reg[r] <= smin;
                amax_reg[r] <= smax;
                sh2_reg[r]  <= sh1_reg[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [33:0] fmin;
        logic signed [33:0] fmax;
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                fmin = 34'(amin_reg[r] >>> FRAC_SHIFT);
                fmax = 34'(amax_reg[r] >>> FRAC_SHIFT);
                wmin_reg[r] <= sat_coord(35'(fmin) + 35'(sh2_reg[r]));
                wmax_reg[r] <= sat_coord(35'(fmax) + 35'(sh2_reg[r]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [NORM_W-1:0] n;
        if (ce) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                for (int c = 0; c < 3; c++) begin
                    n = plane_reg[i][c*NORM_W +: NORM_W];
                    if (n[NORM_W-1]) begin
                        np_reg[i][c] <= n * wmin_reg[c];
                    end else begin
                        np_reg[i][c] <= n * wmax_reg[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [42:0] psum;
        logic               vis;
        if (ce) begin
            vis = 1'b1;
            for (int i = 0; i < PLANE_COUNT; i++) begin
                psum = 43'($signed(plane_reg[i][63:36])) <<< DIST_SHIFT;
                psum = psum + 43'(np_reg[i][0]) + 43'(np_reg[i][1]) + 43'(np_reg[i][2]);
                if (psum[42]) begin
                    vis = 1'b0;
                end
            end
            vis_reg <= vis;
        end
    end

`ifndef SYNTHESIS
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && ce |=> m_tvalid)
        else $error("item lost at last stage");
    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> (wmin_reg[0] <= wmax_reg[0]) && (wmin_reg[1] <= wmax_reg[1])
                       && (wmin_reg[2] <= wmax_reg[2]))
        else $error("world box min above max");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("output padding not zero");
`endif

endmodule
